// ----- rtl/core/baro_pressure_temp_compensation_assert.svh -----
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_assert: assertion macros
// Concurrent checks for the barometer compensation block. The clock is clk
// and the reset is rst_n, both taken from the scope of use.
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

`ifndef SYNTHESIS
`define BPTC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bptc: implication check failed");
`define BPTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bptc: next-cycle check failed");
`else
`define BPTC_ASSERT_IMPLY(label, ante, cons)
`define BPTC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/bptc_pkg.sv -----
// ----------------------------------------------------------------------------
// bptc_pkg: shared definitions for barometer compensation
// Field widths of the streams and the calibration register map.
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TEMP_W    = 19;
  localparam int PRESS_W   = 28;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESSURE_SENS   = 3'd0,
    REG_PRESSURE_OFFSET = 3'd1,
    REG_SENS_TEMPCO     = 3'd2,
    REG_OFFSET_TEMPCO   = 3'd3,
    REG_REF_TEMP        = 3'd4,
    REG_TEMP_SENS       = 3'd5
  } cfg_idx_t;

endpackage

// ----- rtl/core/bptc_if.sv -----
// ----------------------------------------------------------------------------
// bptc_if: valid/ready stream interfaces
// Raw conversion beats in, compensated result beats out.
// ----------------------------------------------------------------------------
interface bptc_in_if;
  logic                         valid;
  logic                         ready;
  logic [bptc_pkg::RAW_W-1:0]   raw_temp;
  logic [bptc_pkg::RAW_W-1:0]   raw_press;

  modport source (output valid, output raw_temp, output raw_press, input ready);
  modport sink   (input valid, input raw_temp, input raw_press, output ready);
endinterface

interface bptc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bptc_pkg::TEMP_W-1:0]  temp_centi;
  logic signed [bptc_pkg::PRESS_W-1:0] press_comp;

  modport source (output valid, output temp_centi, output press_comp, input ready);
  modport sink   (input valid, input temp_centi, input press_comp, output ready);
endinterface

// ----- rtl/core/baro_pressure_temp_compensation.sv -----
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation: 2nd-order barometer temperature compensation
// One beat per cycle sustained while out_bus.ready holds or the pipeline has a free stage.
// Rate is set by the 11-stage pipeline, at most one multiplier rank per stage.
// rst_n (synchronous) empties the pipeline and zeroes the calibration words.
// ----------------------------------------------------------------------------
`include "baro_pressure_temp_compensation_assert.svh"

module baro_pressure_temp_compensation (
  input  logic                            clk,
  input  logic                            rst_n,
  bptc_in_if.sink                         in_bus,
  bptc_out_if.source                      out_bus,
  input  logic                            cfg_wr_en,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bptc_pkg::COEF_W-1:0]     cfg_wdata
);

  localparam int RAW_W   = bptc_pkg::RAW_W;
  localparam int COEF_W  = bptc_pkg::COEF_W;
  localparam int TEMP_W  = bptc_pkg::TEMP_W;
  localparam int PRESS_W = bptc_pkg::PRESS_W;
  localparam int NSTG    = 11;

  localparam int C5_SHIFT   = 8;
  localparam int C2_SHIFT   = 16;
  localparam int C1_SHIFT   = 15;
  localparam int T_SHIFT    = 23;
  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SHIFT = 8;
  localparam int T2_SHIFT   = 31;
  localparam int P_SHIFT1   = 21;
  localparam int P_SHIFT2   = 15;

  localparam int DT_W   = RAW_W + 2;
  localparam int PT_W   = DT_W + COEF_W + 1;
  localparam int PSQ_W  = 2 * DT_W;
  localparam int T_W    = 20;
  localparam int OFF_W  = 37;
  localparam int SENS_W = 36;
  localparam int SQ_W   = 2 * T_W;
  localparam int CORR_W = SQ_W;
  localparam int NET_W  = CORR_W + 1;
  localparam int LO_W   = 20;
  localparam int HI_W   = NET_W - LO_W;
  localparam int PPLO_W = RAW_W + LO_W;
  localparam int PPHI_W = RAW_W + 1 + HI_W;
  localparam int PROD_W = PPHI_W + LO_W;
  localparam int Q_W    = PROD_W - P_SHIFT1;
  localparam int DIFF_W = Q_W + 1;
  localparam int R_W    = DIFF_W - P_SHIFT2;

  localparam logic signed [T_W-1:0] T_REF   = T_W'(2000);
  localparam logic signed [T_W-1:0] T_LOW   = T_W'(-1500);
  localparam logic signed [T_W-1:0] TEMP_HI = T_W'((2 ** (TEMP_W - 1)) - 1);
  localparam logic signed [T_W-1:0] TEMP_LO = T_W'(-(2 ** (TEMP_W - 1)));
  localparam logic signed [R_W-1:0] PRESS_HI = R_W'((2 ** (PRESS_W - 1)) - 1);
  localparam logic signed [R_W-1:0] PRESS_LO = R_W'(-(2 ** (PRESS_W - 1)));

  // calibration words
  logic [COEF_W-1:0] coef_pressure_sens_r;
  logic [COEF_W-1:0] coef_pressure_offset_r;
  logic [COEF_W-1:0] coef_sens_tempco_r;
  logic [COEF_W-1:0] coef_offset_tempco_r;
  logic [COEF_W-1:0] coef_ref_temp_r;
  logic [COEF_W-1:0] coef_temp_sens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_pressure_sens_r   <= '0;
      coef_pressure_offset_r <= '0;
      coef_sens_tempco_r     <= '0;
      coef_offset_tempco_r   <= '0;
      coef_ref_temp_r        <= '0;
      coef_temp_sens_r       <= '0;
    end else if (cfg_wr_en) begin
      unique case (bptc_pkg::cfg_idx_t'(cfg_index))
        bptc_pkg::REG_PRESSURE_SENS:   coef_pressure_sens_r   <= cfg_wdata;
        bptc_pkg::REG_PRESSURE_OFFSET: coef_pressure_offset_r <= cfg_wdata;
        bptc_pkg::REG_SENS_TEMPCO:     coef_sens_tempco_r     <= cfg_wdata;
        bptc_pkg::REG_OFFSET_TEMPCO:   coef_offset_tempco_r   <= cfg_wdata;
        bptc_pkg::REG_REF_TEMP:        coef_ref_temp_r        <= cfg_wdata;
        bptc_pkg::REG_TEMP_SENS:       coef_temp_sens_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline flow control: a stage loads when it or any stage downstream has room, or the output is taken
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] stg_en;

  for (genvar g = 0; g < NSTG; g++) begin : g_en
    assign stg_en[g] = out_bus.ready || !(&vld_r[NSTG-1:g]);
  end

  assign in_bus.ready = stg_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_en[0]) begin
        vld_r[0] <= in_bus.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (stg_en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // payload
  logic [RAW_W-1:0]          d1_r [0:6];
  logic signed [DT_W-1:0]    dt_s0_r;
  logic signed [PT_W-1:0]    pt_s1_r;
  logic signed [PT_W-1:0]    poff_s1_r;
  logic signed [PT_W-1:0]    psens_s1_r;
  logic signed [PSQ_W-1:0]   psq_s1_r;
  logic signed [T_W-1:0]     t_r [2:3];
  logic signed [T_W-1:0]     tcor_r [2:3];
  logic signed [OFF_W-1:0]   off_r [2:5];
  logic signed [SENS_W-1:0]  sens_r [2:5];
  logic signed [T_W-1:0]     dlo_s3_r;
  logic signed [T_W-1:0]     dhi_s3_r;
  logic                      cold_r [3:4];
  logic                      vcold_r [3:4];
  logic signed [SQ_W-1:0]    a_s4_r;
  logic signed [SQ_W-1:0]    b_s4_r;
  logic signed [T_W-1:0]     temp_s4_r;
  logic signed [TEMP_W-1:0]  temp_r [5:10];
  logic [CORR_W-1:0]         offc_s5_r;
  logic [CORR_W-1:0]         sensc_s5_r;
  logic signed [NET_W-1:0]   offn_r [6:8];
  logic signed [NET_W-1:0]   sensn_s6_r;
  logic [PPLO_W-1:0]         pplo_s7_r;
  logic signed [PPHI_W-1:0]  pphi_s7_r;
  logic signed [Q_W-1:0]     q_s8_r;
  logic signed [R_W-1:0]     r_s9_r;
  logic signed [PRESS_W-1:0] press_s10_r;

  // second-order correction terms, all non-negative
  logic [CORR_W-1:0] a_u, b_u, a5, b7, b11, offc_nxt, sensc_nxt;
  logic signed [PROD_W-1:0] prod;
  logic signed [DIFF_W-1:0] diff;
  logic signed [TEMP_W-1:0] temp_sat_nxt;
  logic signed [PRESS_W-1:0] press_sat_nxt;

  always_comb begin
    a_u = CORR_W'(a_s4_r);
    b_u = CORR_W'(b_s4_r);
    a5  = (a_u << 2) + a_u;
    b7  = (b_u << 3) - b_u;
    b11 = (b_u << 3) + (b_u << 1) + b_u;
    offc_nxt  = '0;
    sensc_nxt = '0;
    if (cold_r[4]) begin
      offc_nxt  = (a5 >> 1) + (vcold_r[4] ? b7 : CORR_W'(0));
      sensc_nxt = (a5 >> 2) + (vcold_r[4] ? (b11 >> 1) : CORR_W'(0));
    end

    if (temp_s4_r > TEMP_HI) begin
      temp_sat_nxt = TEMP_W'(TEMP_HI);
    end else if (temp_s4_r < TEMP_LO) begin
      temp_sat_nxt = TEMP_W'(TEMP_LO);
    end else begin
      temp_sat_nxt = TEMP_W'(temp_s4_r);
    end

    prod = (PROD_W'(pphi_s7_r) <<< LO_W) + PROD_W'($signed({1'b0, pplo_s7_r}));
    diff = DIFF_W'(q_s8_r) - DIFF_W'(offn_r[8]);

    if (r_s9_r > PRESS_HI) begin
      press_sat_nxt = PRESS_W'(PRESS_HI);
    end else if (r_s9_r < PRESS_LO) begin
      press_sat_nxt = PRESS_W'(PRESS_LO);
    end else begin
      press_sat_nxt = PRESS_W'(r_s9_r);
    end
  end

  always_ff @(posedge clk) begin
    // stage 0: dT
    if (stg_en[0]) begin
      d1_r[0] <= in_bus.raw_press;
      dt_s0_r <= $signed({2'b00, in_bus.raw_temp})
               - $signed({2'b00, coef_ref_temp_r, {C5_SHIFT{1'b0}}});
    end
    for (int k = 1; k < 7; k++) begin
      if (stg_en[k]) begin
        d1_r[k] <= d1_r[k-1];
      end
    end

    // stage 1: products with dT
    if (stg_en[1]) begin
      pt_s1_r    <= PT_W'(dt_s0_r) * PT_W'($signed({1'b0, coef_temp_sens_r}));
      poff_s1_r  <= PT_W'(dt_s0_r) * PT_W'($signed({1'b0, coef_offset_tempco_r}));
      psens_s1_r <= PT_W'(dt_s0_r) * PT_W'($signed({1'b0, coef_sens_tempco_r}));
      psq_s1_r   <= PSQ_W'(dt_s0_r) * PSQ_W'(dt_s0_r);
    end

    // stage 2: first-order T, OFF, SENS and T2
    if (stg_en[2]) begin
      t_r[2]    <= T_W'(pt_s1_r >>> T_SHIFT) + T_REF;
      tcor_r[2] <= T_W'(psq_s1_r >>> T2_SHIFT);
      off_r[2]  <= OFF_W'($signed({1'b0, coef_pressure_offset_r, {C2_SHIFT{1'b0}}}))
                 + OFF_W'(poff_s1_r >>> OFF_SHIFT);
      sens_r[2] <= SENS_W'($signed({1'b0, coef_pressure_sens_r, {C1_SHIFT{1'b0}}}))
                 + SENS_W'(psens_s1_r >>> SENS_SHIFT);
    end

    // stage 3: threshold tests and offsets for the squares
    if (stg_en[3]) begin
      t_r[3]     <= t_r[2];
      tcor_r[3]  <= tcor_r[2];
      dlo_s3_r   <= t_r[2] - T_REF;
      dhi_s3_r   <= t_r[2] - T_LOW;
      cold_r[3]  <= t_r[2] < T_REF;
      vcold_r[3] <= t_r[2] < T_LOW;
    end
    for (int k = 3; k < 6; k++) begin
      if (stg_en[k]) begin
        off_r[k]  <= off_r[k-1];
        sens_r[k] <= sens_r[k-1];
      end
    end

    // stage 4: squares and corrected temperature
    if (stg_en[4]) begin
      a_s4_r     <= SQ_W'(dlo_s3_r) * SQ_W'(dlo_s3_r);
      b_s4_r     <= SQ_W'(dhi_s3_r) * SQ_W'(dhi_s3_r);
      temp_s4_r  <= t_r[3] - (cold_r[3] ? tcor_r[3] : T_W'(0));
      cold_r[4]  <= cold_r[3];
      vcold_r[4] <= vcold_r[3];
    end

    // stage 5: OFF2, SENS2, temperature clamp
    if (stg_en[5]) begin
      offc_s5_r  <= offc_nxt;
      sensc_s5_r <= sensc_nxt;
      temp_r[5]  <= temp_sat_nxt;
    end
    for (int k = 6; k < NSTG; k++) begin
      if (stg_en[k]) begin
        temp_r[k] <= temp_r[k-1];
      end
    end

    // stage 6: net OFF and SENS
    if (stg_en[6]) begin
      offn_r[6]  <= NET_W'(off_r[5]) - $signed({1'b0, offc_s5_r});
      sensn_s6_r <= NET_W'(sens_r[5]) - $signed({1'b0, sensc_s5_r});
    end
    for (int k = 7; k < 9; k++) begin
      if (stg_en[k]) begin
        offn_r[k] <= offn_r[k-1];
      end
    end

    // stage 7: D1 * SENS as two partial products
    if (stg_en[7]) begin
      pplo_s7_r <= PPLO_W'(d1_r[6]) * PPLO_W'(sensn_s6_r[LO_W-1:0]);
      pphi_s7_r <= PPHI_W'($signed({1'b0, d1_r[6]}))
                 * PPHI_W'($signed(sensn_s6_r[NET_W-1:LO_W]));
    end

    // stage 8: combine partials
    if (stg_en[8]) begin
      q_s8_r <= Q_W'(prod >>> P_SHIFT1);
    end

    // stage 9: subtract OFF
    if (stg_en[9]) begin
      r_s9_r <= R_W'(diff >>> P_SHIFT2);
    end

    // stage 10: pressure clamp, output register
    if (stg_en[10]) begin
      press_s10_r <= press_sat_nxt;
    end
  end

  assign out_bus.valid      = vld_r[NSTG-1];
  assign out_bus.temp_centi = temp_r[10];
  assign out_bus.press_comp = press_s10_r;

  // input stalls only when every stage holds a beat
  `BPTC_ASSERT_IMPLY(a_stall_only_full, !in_bus.ready, &vld_r)
  // the very cold branch is a subset of the cold branch
  `BPTC_ASSERT_IMPLY(a_vcold_in_cold, vld_r[4] && vcold_r[4], cold_r[4])
  // beats in flight change only by accepted input and output beats
  `BPTC_ASSERT_NEXT(a_beat_count, 1'b1, $countones(vld_r) == $countones($past(vld_r)) + $past(in_bus.valid && in_bus.ready) - $past(out_bus.valid && out_bus.ready))

endmodule
